@@ sv/bdlp_pkg.sv @@
// Shared types and constants for the button debouncer with long-press detection.
// No dependencies; every other file in sv/ imports this package.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int BUTTONS              = 4;
  localparam int HISTORY_BITS_DEF     = 16;
  localparam int LONG_PRESS_BITS_DEF  = 8;
  localparam int THR_W                = 16;
  localparam int HOLD_CNT_W           = 16;
  localparam int HOLD_OUT_W           = 8;
  localparam int CFG_IDX_W            = 1;

  localparam logic [THR_W-1:0] PRESS_THR_RST   = 16'h000f;
  localparam logic [THR_W-1:0] RELEASE_THR_RST = 16'hfff0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_LONG     = 2'd3
  } event_t;

  typedef struct packed {
    logic level_3;
    logic level_2;
    logic level_1;
    logic level_0;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            event_3;
    logic [1:0]            event_2;
    logic [1:0]            event_1;
    logic [1:0]            event_0;
    logic [HOLD_OUT_W-1:0] hold_3;
    logic [HOLD_OUT_W-1:0] hold_2;
    logic [HOLD_OUT_W-1:0] hold_1;
    logic [HOLD_OUT_W-1:0] hold_0;
  } out_item_t;

  typedef struct packed {
    event_t                ev;
    logic [HOLD_OUT_W-1:0] hold;
  } lane_res_t;

endpackage

@@ sv/bdlp_lane.sv @@
// One debouncer lane: history shift register, up/down state and hold counter.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_lane import bdlp_pkg::*; #(
  parameter int HISTORY_BITS    = HISTORY_BITS_DEF,
  parameter int LONG_PRESS_BITS = LONG_PRESS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             level,
  input  logic [THR_W-1:0] press_thr,
  input  logic [THR_W-1:0] release_thr,
  output lane_res_t        res
);

  localparam int CMP_W = (HISTORY_BITS > THR_W) ? HISTORY_BITS : THR_W;

  logic [HISTORY_BITS-1:0] history_r, history_nxt;
  logic                    down_r, down_nxt;
  logic [HOLD_CNT_W-1:0]   hold_r, hold_nxt;
  logic [HOLD_CNT_W-1:0]   hold_inc, hold_shift;
  logic [CMP_W-1:0]        hist_ext;
  logic                    rel_hit, prs_hit;

  // new level enters at the top
  assign history_nxt = {level, history_r[HISTORY_BITS-1:1]};
  assign hist_ext    = CMP_W'(history_nxt);
  assign rel_hit     = hist_ext >= CMP_W'(release_thr);
  assign prs_hit     = hist_ext <= CMP_W'(press_thr);
  assign hold_inc    = hold_r + HOLD_CNT_W'(1);
  assign hold_shift  = hold_inc >> LONG_PRESS_BITS;

  always_comb begin
    down_nxt = down_r;
    hold_nxt = hold_r;
    res.ev   = EV_NONE;
    res.hold = '0;
    if (down_r) begin
      // release wins when the thresholds overlap
      if (rel_hit) begin
        down_nxt = 1'b0;
        res.ev   = EV_RELEASED;
      end else if (prs_hit) begin
        hold_nxt = hold_inc;
        if (hold_inc[LONG_PRESS_BITS-1:0] == '0) begin
          res.ev   = EV_LONG;
          res.hold = hold_shift[HOLD_OUT_W-1:0];
        end
      end else begin
        hold_nxt = '0;
      end
    end else if (prs_hit) begin
      down_nxt = 1'b1;
      hold_nxt = '0;
      res.ev   = EV_PRESSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '1;
      down_r    <= 1'b0;
      hold_r    <= '0;
    end else if (adv) begin
      history_r <= history_nxt;
      down_r    <= down_nxt;
      hold_r    <= hold_nxt;
    end
  end

endmodule

@@ sv/bdlp_merge.sv @@
// Merge stage: packs the lane results into one result item and holds it in an
// output register with a skid stage. Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_merge import bdlp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  lane_res_t [BUTTONS-1:0]   lane_res,
  output logic                      skid_full,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data
);

  out_item_t merged;
  out_item_t out_data_r, skid_data_r;
  logic      out_valid_r, skid_valid_r;

  always_comb begin
    merged.event_0 = lane_res[0].ev;
    merged.event_1 = lane_res[1].ev;
    merged.event_2 = lane_res[2].ev;
    merged.event_3 = lane_res[3].ev;
    merged.hold_0  = lane_res[0].hold;
    merged.hold_1  = lane_res[1].hold;
    merged.hold_2  = lane_res[2].hold;
    merged.hold_3  = lane_res[3].hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      // no accept can happen while the skid stage is full
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= merged;
      end
    end else if (accept) begin
      skid_data_r <= merged;
    end
  end

  assign skid_full = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/button_debouncer_long_press_top.sv @@
// Each accepted result is registered in the output register, or in the skid stage
// while the output stalls. Throughput: one sample per cycle unless the skid stage
// is full; each lane does its shift, two compares and the hold count increment
// combinationally, and the skid stage takes one more sample while output stalls.
// Reset (rst_n, synchronous): histories all ones, buttons up, hold counters zero,
// thresholds 0x000f and 0xfff0, output and skid stages empty.
`timescale 1ns / 1ps

module button_debouncer_long_press_top import bdlp_pkg::*; #(
  parameter int HISTORY_BITS    = HISTORY_BITS_DEF,
  parameter int LONG_PRESS_BITS = LONG_PRESS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_wdata
);

  logic [THR_W-1:0]        press_thr_r, release_thr_r;
  logic [BUTTONS-1:0]      levels;
  lane_res_t [BUTTONS-1:0] lane_res;
  logic                    accept, skid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_thr_r   <= PRESS_THR_RST;
      release_thr_r <= RELEASE_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESS_THR:   press_thr_r   <= cfg_wdata;
        CFG_RELEASE_THR: release_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign levels   = {in_data.level_3, in_data.level_2, in_data.level_1, in_data.level_0};
  assign in_ready = !skid_full;
  assign accept   = in_valid && in_ready;

  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    bdlp_lane #(
      .HISTORY_BITS    (HISTORY_BITS),
      .LONG_PRESS_BITS (LONG_PRESS_BITS)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (accept),
      .level       (levels[b]),
      .press_thr   (press_thr_r),
      .release_thr (release_thr_r),
      .res         (lane_res[b])
    );
  end

  bdlp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .lane_res  (lane_res),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/bdlp_checker.sv @@
// Port-level checks for the debouncer top level, attached with a bind.
// Depends on bdlp_pkg and button_debouncer_long_press_top.
`timescale 1ns / 1ps

module bdlp_checker import bdlp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only closes when a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // an accepted sample with a free output shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> out_valid)
    else $error("result missing one cycle after accept");

  // hold byte is only reported on a long press
  a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.hold_0 == '0 || out_data.event_0 == EV_LONG) &&
      (out_data.hold_1 == '0 || out_data.event_1 == EV_LONG) &&
      (out_data.hold_2 == '0 || out_data.event_2 == EV_LONG) &&
      (out_data.hold_3 == '0 || out_data.event_3 == EV_LONG))
    else $error("hold byte set without long press");

endmodule

bind button_debouncer_long_press_top bdlp_checker u_bdlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ bench/button_debouncer_long_press_top_tb.sv @@
// Self-checking bench for button_debouncer_long_press_top: debounced press, release and
// long-press events of four buttons predicted per sample and compared per field.
// Depends on bdlp_pkg and the top module in sv/.
`timescale 1ns / 1ps

module button_debouncer_long_press_top_tb;
  import bdlp_pkg::*;

  typedef struct {
    in_item_t  lv;
    bit        typed;
    out_item_t res;
  } sample_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PRESS_THR;
  logic [THR_W-1:0]     cfg_wdata = '0;

  button_debouncer_long_press_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("** button_debouncer_long_press_top: FAILED **");
    $finish;
  end

  // predictor state
  logic [HISTORY_BITS_DEF-1:0] hist_m [BUTTONS];
  bit                          down_m [BUTTONS];
  logic [HOLD_CNT_W-1:0]       cnt_m  [BUTTONS];
  logic [THR_W-1:0]            press_thr_m;
  logic [THR_W-1:0]            release_thr_m;

  out_item_t   pending_events[$];
  int          mismatches = 0;
  int          results_seen = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          rush = 1'b0;
  sample_row_t dir_rows [25];

  // stimulus shaping: per-button run of one level with contact bounce
  logic        lvl_cur  [BUTTONS];
  int          run_left [BUTTONS];
  int          run_age  [BUTTONS];

  function automatic lane_res_t lane_of(out_item_t o, int b);
    lane_res_t r;
    case (b)
      0: r = '{ev: event_t'(o.event_0), hold: o.hold_0};
      1: r = '{ev: event_t'(o.event_1), hold: o.hold_1};
      2: r = '{ev: event_t'(o.event_2), hold: o.hold_2};
      default: r = '{ev: event_t'(o.event_3), hold: o.hold_3};
    endcase
    return r;
  endfunction

  function automatic out_item_t with_lane(out_item_t o, int b, lane_res_t r);
    case (b)
      0: begin
        o.event_0 = r.ev;
        o.hold_0  = r.hold;
      end
      1: begin
        o.event_1 = r.ev;
        o.hold_1  = r.hold;
      end
      2: begin
        o.event_2 = r.ev;
        o.hold_2  = r.hold;
      end
      default: begin
        o.event_3 = r.ev;
        o.hold_3  = r.hold;
      end
    endcase
    return o;
  endfunction

  task automatic reset_model();
    press_thr_m   = PRESS_THR_RST;
    release_thr_m = RELEASE_THR_RST;
    for (int b = 0; b < BUTTONS; b++) begin
      hist_m[b]   = '1;
      down_m[b]   = 1'b0;
      cnt_m[b]    = '0;
      lvl_cur[b]  = 1'b1;
      run_left[b] = 0;
      run_age[b]  = 0;
    end
  endtask

  function automatic out_item_t predict_events(in_item_t x);
    out_item_t                   o;
    lane_res_t                   r;
    logic [HISTORY_BITS_DEF-1:0] h;
    logic [BUTTONS-1:0]          lv;
    o  = '0;
    lv = x;
    for (int b = 0; b < BUTTONS; b++) begin
      h = {lv[b], hist_m[b][HISTORY_BITS_DEF-1:1]};
      hist_m[b] = h;
      r.ev   = EV_NONE;
      r.hold = '0;
      if (down_m[b]) begin
        // release wins when the thresholds overlap
        if (h >= release_thr_m) begin
          down_m[b] = 1'b0;
          r.ev = EV_RELEASED;
        end else if (h <= press_thr_m) begin
          cnt_m[b] = cnt_m[b] + 1'b1;
          if ((cnt_m[b] & ((1 << LONG_PRESS_BITS_DEF) - 1)) == 0) begin
            r.ev   = EV_LONG;
            r.hold = HOLD_OUT_W'(cnt_m[b] >> LONG_PRESS_BITS_DEF);
          end
        end else begin
          cnt_m[b] = '0;
        end
      end else if (h <= press_thr_m) begin
        cnt_m[b]  = '0;
        down_m[b] = 1'b1;
        r.ev = EV_PRESSED;
      end
      o = with_lane(o, b, r);
    end
    return o;
  endfunction

  function automatic in_item_t next_sample(bit noisy);
    logic [BUTTONS-1:0] lv;
    for (int b = 0; b < BUTTONS; b++) begin
      if (noisy) begin
        lv[b] = $urandom_range(0, 1);
      end else begin
        if (run_left[b] == 0) begin
          lvl_cur[b] = ~lvl_cur[b];
          run_age[b] = 0;
          case ($urandom_range(0, 3))
            0:       run_left[b] = $urandom_range(1, 8);
            3:       run_left[b] = $urandom_range(260, 420);
            default: run_left[b] = $urandom_range(16, 64);
          endcase
        end
        run_left[b]--;
        run_age[b]++;
        lv[b] = lvl_cur[b];
        if (run_age[b] <= 6 && $urandom_range(0, 3) == 0) begin
          lv[b] = ~lv[b];
        end else if ($urandom_range(0, 63) == 0) begin
          lv[b] = ~lv[b];
        end
      end
    end
    return in_item_t'(lv);
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    lane_res_t g;
    lane_res_t w;
    if (pending_events.size() == 0) begin
      flag_mismatch("result with no pending sample");
    end else begin
      want = pending_events.pop_front();
      for (int b = 0; b < BUTTONS; b++) begin
        g = lane_of(got, b);
        w = lane_of(want, b);
        if (g.ev !== w.ev)
          flag_mismatch($sformatf("event_%0d got %0d expected %0d", b, g.ev, w.ev));
        if (g.hold !== w.hold)
          flag_mismatch($sformatf("hold_%0d got %0d expected %0d", b, g.hold, w.hold));
      end
    end
    results_seen++;
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_sample(in_item_t x, bit typed, out_item_t typed_res);
    int        gap;
    out_item_t pred;
    if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
    gap = (tx_calm || rush) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pred = predict_events(x);
    pending_events.push_back(typed ? typed_res : pred);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      send_sample(next_sample($urandom_range(0, 7) == 0), 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [THR_W-1:0] press, logic [THR_W-1:0] rel);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRESS_THR;
    cfg_wdata <= press;
    @(posedge clk);
    cfg_index <= CFG_RELEASE_THR;
    cfg_wdata <= rel;
    @(posedge clk);
    cfg_we <= 1'b0;
    press_thr_m   = press;
    release_thr_m = rel;
  endtask

  // result side
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
      stall = (rx_calm || rush) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      check_result(out_data);
    end
  end

  initial begin
    reset_model();
    // buttons 0 and 3 go down after twelve low samples, button 0 comes back up
    // after twelve high ones, button 2 chatters and never settles
    for (int i = 0; i < 25; i++) begin
      dir_rows[i].lv.level_0 = (i == 0) || (i >= 13);
      dir_rows[i].lv.level_1 = 1'b1;
      dir_rows[i].lv.level_2 = (i % 2 == 1);
      dir_rows[i].lv.level_3 = (i == 0);
      dir_rows[i].typed      = 1'b0;
      dir_rows[i].res        = '0;
    end
    dir_rows[0].typed          = 1'b1;
    dir_rows[12].typed         = 1'b1;
    dir_rows[12].res.event_0   = EV_PRESSED;
    dir_rows[12].res.event_3   = EV_PRESSED;
    dir_rows[24].typed         = 1'b1;
    dir_rows[24].res.event_0   = EV_RELEASED;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      send_sample(dir_rows[i].lv, dir_rows[i].typed, dir_rows[i].res);
    end
    run_random(180);

    drain();
    write_thresholds(16'h0000, 16'hffff);
    run_random(150);

    // overlapping thresholds: release takes priority
    drain();
    write_thresholds(16'hffff, 16'h0000);
    run_random(30);

    drain();
    write_thresholds(16'h00ff, 16'hff00);
    run_random(150);

    drain();
    write_thresholds(THR_W'($urandom_range(0, 16'h0fff)),
                     THR_W'($urandom_range(16'hf000, 16'hffff)));
    run_random(150);

    drain();
    write_thresholds(THR_W'($urandom), THR_W'($urandom));
    run_random(60);

    // hold every button long enough for a long-press event
    drain();
    write_thresholds(PRESS_THR_RST, RELEASE_THR_RST);
    rush = 1'b1;
    for (int i = 0; i < 300; i++) send_sample('0, 1'b0, '0);
    for (int i = 0; i < 24; i++) send_sample('1, 1'b0, '0);
    in_valid <= 1'b0;
    rush = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("** button_debouncer_long_press_top: PASSED **");
    end else begin
      $display("** button_debouncer_long_press_top: FAILED **");
    end
    $finish;
  end

endmodule
